[rtl/core/tfsc_pkg.sv]
// Package for the target-follow speed controller: field widths, input codes,
// sequencer states and a shared helper function. No dependencies.
package tfsc_pkg;

	localparam int POS_W  = 20;
	localparam int HD_W   = 14;
	localparam int SPD_W  = 14;
	localparam int TIME_W = 32;
	localparam int DIST_W = 16;
	localparam int GAIN_W = 13;
	localparam int MAXS_W = 13;
	localparam int TOUT_W = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int WINDOW_LEN_DEF = 10;

	// shared arithmetic widths
	localparam int MUL_W  = 21;
	localparam int RAD_W  = 2 * MUL_W;
	localparam int ROOT_W = MUL_W;
	localparam int NUM_W  = 40;
	localparam int DEN_W  = 32;

	localparam logic [MUL_W-1:0] SCALE_US   = 21'd1000000;
	localparam logic [SPD_W-1:0] IDLE_SPEED = 14'd512;
	localparam logic [SPD_W-1:0] SPD_MAX    = 14'h1fff;
	localparam logic [SPD_W-1:0] SPD_MIN    = 14'h2000;

	// divide by five as a multiply by ceil(2^18 / 5), exact below 2^18
	localparam logic [MUL_W-1:0] RECIP_FIVE  = 21'd52429;
	localparam int               RECIP_SH    = 18;
	localparam int               FIVE_IN_W   = 17;
	localparam int               COMP_CLAMP  = 32767;
	localparam logic [MUL_W-1:0] FIVE_IN_MAX = 21'd131068;

	localparam logic [DIST_W-1:0] RST_SPACING_DIST = 16'd512;
	localparam logic [GAIN_W-1:0] RST_SPACING_GAIN = 13'd1024;
	localparam logic [MAXS_W-1:0] RST_MAX_SPEED    = 13'd1536;
	localparam logic [TOUT_W-1:0] RST_TIMEOUT      = 5'd8;

	typedef enum logic [2:0] {
		FN_SIGHTING = 3'd0,
		FN_TICK     = 3'd1,
		FN_POSE     = 3'd2,
		FN_ENABLE   = 3'd3,
		FN_DISABLE  = 3'd4
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPACING_DIST = 2'd0,
		CFG_SPACING_GAIN = 2'd1,
		CFG_MAX_SPEED    = 2'd2,
		CFG_TIMEOUT      = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_DX,
		ST_MUL_DY,
		ST_SQRT_REL,
		ST_MUL_PX,
		ST_MUL_PY,
		ST_SQRT_ORG,
		ST_MUL_SPD,
		ST_DIV_SPD,
		ST_WRITE,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_DIV_AVG,
		ST_DIV_FIVE_A,
		ST_MUL_COMP,
		ST_DIV_COMP,
		ST_DIV_FIVE_B,
		ST_FINISH
	} state_t;

	function automatic logic [MUL_W-1:0] abs21(input logic signed [MUL_W-1:0] v);
		abs21 = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
	endfunction

endpackage

[rtl/core/tfsc_if.sv]
// Channel interfaces for the target-follow speed controller: input items,
// result items and configuration writes. Depends on tfsc_pkg.
interface tfsc_item_if;
	logic                                valid;
	logic                                ready;
	logic [2:0]                          func;
	logic signed [tfsc_pkg::POS_W-1:0]   pos_x;
	logic signed [tfsc_pkg::POS_W-1:0]   pos_y;
	logic signed [tfsc_pkg::HD_W-1:0]    heading;
	logic signed [tfsc_pkg::SPD_W-1:0]   own_speed;
	logic [tfsc_pkg::TIME_W-1:0]         time_us;

	modport source (output valid, func, pos_x, pos_y, heading, own_speed, time_us,
		input ready);
	modport sink (input valid, func, pos_x, pos_y, heading, own_speed, time_us,
		output ready);
endinterface

interface tfsc_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [tfsc_pkg::POS_W-1:0]   cmd_x;
	logic signed [tfsc_pkg::POS_W-1:0]   cmd_y;
	logic signed [tfsc_pkg::HD_W-1:0]    cmd_heading;
	logic signed [tfsc_pkg::SPD_W-1:0]   cmd_speed;

	modport source (output valid, cmd_x, cmd_y, cmd_heading, cmd_speed, input ready);
	modport sink (input valid, cmd_x, cmd_y, cmd_heading, cmd_speed, output ready);
endinterface

interface tfsc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [tfsc_pkg::CFG_IDX_W-1:0]      index;
	logic [tfsc_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/tfsc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module tfsc_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 10,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

[rtl/core/tfsc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tfsc_pkg for the operand widths.
module tfsc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tfsc_pkg::NUM_W-1:0] num,
	input  logic [tfsc_pkg::DEN_W-1:0] den,
	output logic                       done,
	output logic [tfsc_pkg::NUM_W-1:0] quo
);
	localparam int NW = tfsc_pkg::NUM_W;
	localparam int DW = tfsc_pkg::DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          ge;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q <= ge ? (shifted - {1'b0, den_q}) : shifted;
				quo_q <= {quo_q[NW-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while still busy");
endmodule

[rtl/core/tfsc_sqrt.sv]
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on tfsc_pkg for the operand widths.
module tfsc_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tfsc_pkg::RAD_W-1:0]  rad,
	output logic                        done,
	output logic [tfsc_pkg::ROOT_W-1:0] root
);
	localparam int RW = tfsc_pkg::RAD_W;
	localparam int OW = tfsc_pkg::ROOT_W;
	localparam int MW = OW + 3;
	localparam int CW = $clog2(OW + 1);

	logic [RW-1:0] rad_q;
	logic [MW-1:0] rem_q;
	logic [OW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [MW-1:0] cur;
	logic [MW-1:0] trial;
	logic          ge;

	assign cur   = {rem_q[MW-3:0], rad_q[RW-1:RW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(OW);
				rad_q  <= rad;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q  <= {rad_q[RW-3:0], 2'b00};
				rem_q  <= ge ? (cur - trial) : cur;
				root_q <= {root_q[OW-2:0], ge};
				cnt_q  <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

[rtl/core/target_follow_speed_controller.sv]
// Target-follow speed controller top level; depends on tfsc_pkg, tfsc_if, tfsc_ram,
// tfsc_div and tfsc_sqrt.
// Tick, pose update, enable and disable: one beat a cycle while no result waits untaken;
// a tick result shows the cycle after acceptance and holds the input until taken.
// Sighting: input held through two roots, one to three divides and a read and an
// accumulate step per window entry. Reset initialises all state but the window RAM.
module target_follow_speed_controller #(
	parameter int WINDOW_LEN = tfsc_pkg::WINDOW_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tfsc_item_if.sink   item,
	tfsc_result_if.source result,
	tfsc_cfg_if.sink    cfg
);
	localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int FW = $clog2(WINDOW_LEN + 1);
	localparam int SW = tfsc_pkg::SPD_W + FW;
	localparam int PW = tfsc_pkg::POS_W;
	localparam int HW = tfsc_pkg::HD_W;
	localparam int VW = tfsc_pkg::SPD_W;
	localparam int MW = tfsc_pkg::MUL_W;
	localparam int NW = tfsc_pkg::NUM_W;
	localparam int DW = tfsc_pkg::DEN_W;
	localparam int CMW = NW + 2;

	tfsc_pkg::state_t state_q, state_d;

	// configuration
	logic [tfsc_pkg::DIST_W-1:0] spacing_dist_q;
	logic [tfsc_pkg::GAIN_W-1:0] spacing_gain_q;
	logic [tfsc_pkg::MAXS_W-1:0] max_speed_q;
	logic [tfsc_pkg::TOUT_W-1:0] timeout_cfg_q;

	// architectural state
	logic signed [PW-1:0] tpx_q, tpy_q, cur_px_q, cur_py_q;
	logic signed [HW-1:0] thd_q, cur_hd_q;
	logic signed [VW-1:0] cur_spd_q, command_spd_q;
	logic [tfsc_pkg::TIME_W-1:0] last_stamp_q;
	logic [PW-1:0]        last_origin_q;
	logic [FW-1:0]        fill_q;
	logic [AW-1:0]        slot_q;
	logic signed [5:0]    timeout_q;
	logic                 following_q, was_following_q;

	// sighting working registers
	logic [DW-1:0]        dt_q;
	logic [MW-1:0]        dxm_q, dym_q, pxm_q, pym_q, delm_q;
	logic                 del_neg_q, avg_neg_q, close_q;
	logic [MW-1:0]        rel_q;
	logic [2*MW-1:0]      acc_q;
	logic signed [VW-1:0] spd_q;
	logic signed [SW-1:0] sum_q;
	logic [FW-1:0]        idx_q;
	logic                 issued_q;

	// result register
	logic                 res_valid_q;
	logic signed [PW-1:0] res_x_q, res_y_q;
	logic signed [HW-1:0] res_hd_q;
	logic signed [VW-1:0] res_spd_q;

	// shared units
	logic            div_start, div_done, sq_start, sq_done;
	logic [NW-1:0]   div_num, div_quo;
	logic [DW-1:0]   div_den;
	logic [MW-1:0]   sq_root;
	logic [MW-1:0]   mul_a, mul_b;
	logic [2*MW-1:0] prod;
	logic            ram_we;
	logic [VW-1:0]   ram_rdata;

	logic                        item_acc;
	logic [tfsc_pkg::DIST_W-1:0] dist_eff;
	logic [MW-1:0]               rel_excess;
	logic [SW-1:0]               sum_abs;
	logic signed [MW-1:0]        dx, dy, delta;
	logic signed [5:0]           tick_dec;
	logic                        expired, fol_next;
	logic [MW-1:0]               five_in;
	logic [NW-1:0]               five_quo;
	logic signed [CMW-1:0]       cand;
	logic signed [VW-1:0]        cmd_capped;
	logic signed [VW-1:0]        spd_sat;

	assign item_acc   = item.valid && item.ready;
	assign item.ready = (state_q == tfsc_pkg::ST_IDLE) && (!res_valid_q || result.ready);
	assign cfg.ready  = 1'b1;

	assign dist_eff   = (spacing_dist_q == '0) ? tfsc_pkg::DIST_W'(1) : spacing_dist_q;
	assign rel_excess = rel_q - MW'(dist_eff);
	assign sum_abs    = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign dx = MW'(item.pos_x) - MW'(cur_px_q);
	assign dy = MW'(item.pos_y) - MW'(cur_py_q);
	assign delta = $signed({1'b0, sq_root[PW-1:0]}) - $signed({1'b0, last_origin_q});
	assign prod  = mul_a * mul_b;

	// four times the quotient; a larger compensation caps the command anyway
	assign five_in  = (div_quo > NW'(tfsc_pkg::COMP_CLAMP)) ? tfsc_pkg::FIVE_IN_MAX
		: MW'({div_quo[tfsc_pkg::FIVE_IN_W-3:0], 2'b00});
	assign five_quo = NW'(acc_q[tfsc_pkg::RECIP_SH +: tfsc_pkg::FIVE_IN_W]);

	assign tick_dec = timeout_q - 6'sd1;
	assign expired  = tick_dec[5];
	assign fol_next = following_q && !expired;

	always_comb begin
		if (del_neg_q) begin
			spd_sat = (div_quo > NW'(8192)) ? tfsc_pkg::SPD_MIN : VW'(-div_quo[VW-1:0]);
		end else begin
			spd_sat = (div_quo > NW'(8191)) ? tfsc_pkg::SPD_MAX : VW'(div_quo[VW-1:0]);
		end
	end

	always_comb begin
		if (close_q) begin
			cand = avg_neg_q ? -$signed({2'b00, five_quo}) : $signed({2'b00, five_quo});
		end else begin
			cand = CMW'(cur_spd_q) + $signed({2'b00, five_quo});
		end
		if (cand > $signed(CMW'(max_speed_q))) begin
			cmd_capped = VW'(max_speed_q);
		end else if (cand < -$signed(CMW'(8192))) begin
			cmd_capped = tfsc_pkg::SPD_MIN;
		end else begin
			cmd_capped = cand[VW-1:0];
		end
	end

	always_comb begin
		unique case (state_q)
			tfsc_pkg::ST_MUL_DX:   begin mul_a = dxm_q; mul_b = dxm_q; end
			tfsc_pkg::ST_MUL_DY:   begin mul_a = dym_q; mul_b = dym_q; end
			tfsc_pkg::ST_MUL_PX:   begin mul_a = pxm_q; mul_b = pxm_q; end
			tfsc_pkg::ST_MUL_PY:   begin mul_a = pym_q; mul_b = pym_q; end
			tfsc_pkg::ST_MUL_SPD:  begin mul_a = delm_q; mul_b = tfsc_pkg::SCALE_US; end
			tfsc_pkg::ST_MUL_COMP: begin mul_a = MW'(spacing_gain_q); mul_b = rel_excess; end
			tfsc_pkg::ST_DIV_FIVE_A, tfsc_pkg::ST_DIV_FIVE_B: begin
				mul_a = five_in;
				mul_b = tfsc_pkg::RECIP_FIVE;
			end
			default:               begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and unit launches
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		sq_start  = 1'b0;
		div_num   = '0;
		div_den   = '0;
		ram_we    = 1'b0;
		unique case (state_q)
			tfsc_pkg::ST_IDLE: begin
				if (item_acc && item.func == tfsc_pkg::FN_SIGHTING) begin
					state_d = tfsc_pkg::ST_MUL_DX;
				end
			end
			tfsc_pkg::ST_MUL_DX: state_d = tfsc_pkg::ST_MUL_DY;
			tfsc_pkg::ST_MUL_DY: state_d = tfsc_pkg::ST_SQRT_REL;
			tfsc_pkg::ST_SQRT_REL: begin
				sq_start = !issued_q;
				if (sq_done) state_d = tfsc_pkg::ST_MUL_PX;
			end
			tfsc_pkg::ST_MUL_PX: state_d = tfsc_pkg::ST_MUL_PY;
			tfsc_pkg::ST_MUL_PY: state_d = tfsc_pkg::ST_SQRT_ORG;
			tfsc_pkg::ST_SQRT_ORG: begin
				sq_start = !issued_q;
				if (sq_done) state_d = tfsc_pkg::ST_MUL_SPD;
			end
			tfsc_pkg::ST_MUL_SPD: begin
				state_d = (dt_q == '0) ? tfsc_pkg::ST_WRITE : tfsc_pkg::ST_DIV_SPD;
			end
			tfsc_pkg::ST_DIV_SPD: begin
				div_start = !issued_q;
				div_num   = acc_q[NW-1:0];
				div_den   = dt_q;
				if (div_done) state_d = tfsc_pkg::ST_WRITE;
			end
			tfsc_pkg::ST_WRITE: begin
				ram_we  = 1'b1;
				state_d = tfsc_pkg::ST_SUM_RD;
			end
			tfsc_pkg::ST_SUM_RD: state_d = tfsc_pkg::ST_SUM_ACC;
			tfsc_pkg::ST_SUM_ACC: begin
				state_d = (idx_q + FW'(1) == fill_q) ? tfsc_pkg::ST_DIV_AVG
					: tfsc_pkg::ST_SUM_RD;
			end
			tfsc_pkg::ST_DIV_AVG: begin
				div_start = !issued_q;
				div_num   = NW'(sum_abs);
				div_den   = DW'(fill_q);
				if (div_done) begin
					state_d = (rel_q < MW'(dist_eff)) ? tfsc_pkg::ST_DIV_FIVE_A
						: tfsc_pkg::ST_MUL_COMP;
				end
			end
			tfsc_pkg::ST_DIV_FIVE_A, tfsc_pkg::ST_DIV_FIVE_B: state_d = tfsc_pkg::ST_FINISH;
			tfsc_pkg::ST_MUL_COMP: state_d = tfsc_pkg::ST_DIV_COMP;
			tfsc_pkg::ST_DIV_COMP: begin
				div_start = !issued_q;
				div_num   = acc_q[NW-1:0];
				div_den   = DW'(dist_eff);
				if (div_done) state_d = tfsc_pkg::ST_DIV_FIVE_B;
			end
			tfsc_pkg::ST_FINISH: state_d = tfsc_pkg::ST_IDLE;
			default: state_d = tfsc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_dist_q <= tfsc_pkg::RST_SPACING_DIST;
			spacing_gain_q <= tfsc_pkg::RST_SPACING_GAIN;
			max_speed_q    <= tfsc_pkg::RST_MAX_SPEED;
			timeout_cfg_q  <= tfsc_pkg::RST_TIMEOUT;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tfsc_pkg::CFG_SPACING_DIST: spacing_dist_q <= cfg.data;
				tfsc_pkg::CFG_SPACING_GAIN: spacing_gain_q <= cfg.data[tfsc_pkg::GAIN_W-1:0];
				tfsc_pkg::CFG_MAX_SPEED:    max_speed_q    <= cfg.data[tfsc_pkg::MAXS_W-1:0];
				tfsc_pkg::CFG_TIMEOUT:      timeout_cfg_q  <= cfg.data[tfsc_pkg::TOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpx_q <= '0; tpy_q <= '0; thd_q <= '0;
			cur_px_q <= '0; cur_py_q <= '0; cur_hd_q <= '0; cur_spd_q <= '0;
			command_spd_q <= '0;
			last_stamp_q <= '0;
			last_origin_q <= '0;
			fill_q <= '0;
			slot_q <= '0;
			timeout_q <= -6'sd1;
			following_q <= 1'b0;
			was_following_q <= 1'b0;
			dt_q <= '0;
			dxm_q <= '0; dym_q <= '0; pxm_q <= '0; pym_q <= '0; delm_q <= '0;
			del_neg_q <= 1'b0; avg_neg_q <= 1'b0; close_q <= 1'b0;
			rel_q <= '0;
			acc_q <= '0;
			spd_q <= '0;
			sum_q <= '0;
			idx_q <= '0;
			issued_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_x_q <= '0; res_y_q <= '0; res_hd_q <= '0; res_spd_q <= '0;
		end else begin
			if (div_start || sq_start) begin
				issued_q <= 1'b1;
			end else if (div_done || sq_done) begin
				issued_q <= 1'b0;
			end
			if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				tfsc_pkg::ST_IDLE: begin
					if (item_acc) begin
						unique case (item.func)
							tfsc_pkg::FN_SIGHTING: begin
								timeout_q    <= 6'(timeout_cfg_q);
								tpx_q        <= item.pos_x;
								tpy_q        <= item.pos_y;
								thd_q        <= item.heading;
								dt_q         <= item.time_us - last_stamp_q;
								last_stamp_q <= item.time_us;
								dxm_q        <= tfsc_pkg::abs21(dx);
								dym_q        <= tfsc_pkg::abs21(dy);
								pxm_q        <= tfsc_pkg::abs21(MW'(item.pos_x));
								pym_q        <= tfsc_pkg::abs21(MW'(item.pos_y));
							end
							tfsc_pkg::FN_TICK: begin
								timeout_q <= expired ? -6'sd1 : tick_dec;
								if (expired && following_q) begin
									command_spd_q <= '0;
								end
								following_q     <= fol_next;
								was_following_q <= fol_next;
								if (fol_next) begin
									res_x_q   <= tpx_q;
									res_y_q   <= tpy_q;
									res_hd_q  <= thd_q;
									res_spd_q <= command_spd_q;
									if (command_spd_q > 0) res_valid_q <= 1'b1;
								end else begin
									cur_spd_q <= '0;
									res_x_q   <= cur_px_q;
									res_y_q   <= cur_py_q;
									res_hd_q  <= cur_hd_q;
									res_spd_q <= tfsc_pkg::IDLE_SPEED;
									if (was_following_q) res_valid_q <= 1'b1;
								end
							end
							tfsc_pkg::FN_POSE: begin
								cur_px_q  <= item.pos_x;
								cur_py_q  <= item.pos_y;
								cur_hd_q  <= item.heading;
								cur_spd_q <= item.own_speed;
							end
							tfsc_pkg::FN_ENABLE:  following_q <= 1'b1;
							tfsc_pkg::FN_DISABLE: following_q <= 1'b0;
							default: ;
						endcase
					end
				end
				tfsc_pkg::ST_MUL_DX, tfsc_pkg::ST_MUL_PX,
				tfsc_pkg::ST_MUL_SPD, tfsc_pkg::ST_MUL_COMP,
				tfsc_pkg::ST_DIV_FIVE_A, tfsc_pkg::ST_DIV_FIVE_B: begin
					acc_q <= prod;
					if (state_q == tfsc_pkg::ST_MUL_SPD) spd_q <= '0;
				end
				tfsc_pkg::ST_MUL_DY, tfsc_pkg::ST_MUL_PY: acc_q <= acc_q + prod;
				tfsc_pkg::ST_SQRT_REL: begin
					if (sq_done) rel_q <= sq_root;
				end
				tfsc_pkg::ST_SQRT_ORG: begin
					if (sq_done) begin
						last_origin_q <= sq_root[PW-1:0];
						del_neg_q     <= delta[MW-1];
						delm_q        <= tfsc_pkg::abs21(delta);
					end
				end
				tfsc_pkg::ST_DIV_SPD: begin
					if (div_done) spd_q <= spd_sat;
				end
				tfsc_pkg::ST_WRITE: begin
					slot_q <= (slot_q == AW'(WINDOW_LEN - 1)) ? '0 : slot_q + AW'(1);
					if (fill_q != FW'(WINDOW_LEN)) fill_q <= fill_q + FW'(1);
					idx_q <= '0;
					sum_q <= '0;
				end
				tfsc_pkg::ST_SUM_ACC: begin
					sum_q <= sum_q + SW'($signed(ram_rdata));
					idx_q <= idx_q + FW'(1);
				end
				tfsc_pkg::ST_DIV_AVG: begin
					if (div_done) begin
						avg_neg_q <= sum_q[SW-1];
						close_q   <= rel_q < MW'(dist_eff);
					end
				end
				tfsc_pkg::ST_FINISH: command_spd_q <= cmd_capped;
				default: ;
			endcase
		end
	end

	tfsc_ram #(
		.WIDTH(VW),
		.DEPTH(WINDOW_LEN),
		.AW   (AW)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(spd_q),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	tfsc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	tfsc_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.rad   (acc_q),
		.done  (sq_done),
		.root  (sq_root)
	);

	assign result.valid       = res_valid_q;
	assign result.cmd_x       = res_x_q;
	assign result.cmd_y       = res_y_q;
	assign result.cmd_heading = res_hd_q;
	assign result.cmd_speed   = res_spd_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> state_q == tfsc_pkg::ST_IDLE)
		else $error("input ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_LEN) && slot_q <= AW'(WINDOW_LEN - 1))
		else $error("window fill or slot out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == tfsc_pkg::ST_DIV_SPD || state_q == tfsc_pkg::ST_DIV_AVG
			|| state_q == tfsc_pkg::ST_DIV_COMP))
		else $error("divider launched outside a divide step");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tfsc_pkg::ST_SUM_ACC |-> idx_q < fill_q)
		else $error("window sum past filled entries");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> $stable(res_spd_q))
		else $error("held result overwritten");
endmodule
